@@ design/pnc_pkg.sv @@
`default_nettype none
package pnc_pkg;
  localparam int unsigned PaletteDepthDefault = 256;
  localparam int unsigned ColorW = 32;
  localparam int unsigned IndexW = 8;
  localparam int unsigned CountW = 9;

  typedef enum logic [1:0] {
    ActClear    = 2'd0,
    ActLoad     = 2'd1,
    ActQuantize = 2'd2,
    ActNone     = 2'd3
  } action_e;

  function automatic logic [9:0] key_sum(input logic [31:0] c);
    key_sum = 10'(c[7:0]) + 10'(c[15:8]) + 10'(c[23:16]) + 10'(c[31:24]);
  endfunction

  // Ordering key: sum, then a, r, g, b.
  function automatic logic [41:0] order_key(input logic [31:0] c);
    order_key = {key_sum(c), c[31:24], c[7:0], c[15:8], c[23:16]};
  endfunction
endpackage
`default_nettype wire

@@ design/pnc_if.sv @@
`default_nettype none
interface pnc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] color;
  modport source (output valid, action, color, input ready);
  modport sink (input valid, action, color, output ready);
endinterface

interface pnc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;
  logic [8:0] entry_count;
  modport source (output valid, color_index, entry_count, input ready);
  modport sink (input valid, color_index, entry_count, output ready);
endinterface
`default_nettype wire

@@ design/palette_nearest_color_core.sv @@
// Steps: clear goes straight to the result; load shifts up each entry that orders
//   above the new word, then writes it; quantize runs an exact match scan, a sort
//   position scan and a walk over the neighbors.
// Throughput: one word at a time; ready again in the cycle after the result leaves.
// Reset: rst_ni asynchronous active low clears count and control; palette RAM
//   content is undefined until loaded.
`default_nettype none
module palette_nearest_color_core
  import pnc_pkg::*;
#(
  parameter int unsigned PaletteDepth = PaletteDepthDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  pnc_in_if.sink   in_i,
  pnc_out_if.source out_o
);
  localparam int unsigned AW = $clog2(PaletteDepth);
  localparam int unsigned NW = $clog2(PaletteDepth + 1);

  typedef enum logic [3:0] {
    SIdle, SLdRd, SLdWt, SLdCmp, SMatRd, SMatWt, SMatCmp,
    SPosRd, SPosWt, SPosCmp, SWalkRd, SWalkWt, SWalkD, SWalkCmp, SOut
  } state_e;

  state_e       state_q;
  logic [NW-1:0] count_q;
  logic [31:0]  color_q;
  logic [NW-1:0] ptr_q;     // current RAM index
  logic [NW-1:0] pos_q, best_q;
  logic [17:0]  bestd_q;
  logic         up_q, first_q;
  logic [7:0]   idx_q;
  logic         ovalid_q;
  logic [8:0]   ocount_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic [17:0]   dist_sq;
  logic [10:0]   dsum;
  logic signed [21:0] dsum_w;
  logic [21:0]   sq;

  pnc_ram #(.Width(ColorW), .Depth(PaletteDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );
  pnc_dist u_dist (.clk_i, .entry_i(rdata), .color_i(color_q), .dist_o(dist_sq), .sum_o(dsum));

  // Sign-extend the difference sum before squaring so the product keeps all bits.
  assign dsum_w = 22'($signed(dsum));
  assign sq = unsigned'(dsum_w * dsum_w) >> 2;

  // RAM: read at ptr-1 in SLdRd and SLdWt, ptr otherwise; write at ptr in SLdCmp, and at 0 in SLdRd when ptr is 0.
  always_comb begin
    raddr = AW'(ptr_q);
    if (state_q == SLdRd || state_q == SLdWt) raddr = AW'(ptr_q - NW'(1));
    we    = 1'b0;
    waddr = AW'(ptr_q);
    wdata = rdata;
    if (state_q == SLdCmp) begin
      we = 1'b1;
      if (order_key(color_q) < order_key(rdata)) wdata = rdata;
      else wdata = color_q;
    end else if (state_q == SLdRd && ptr_q == '0) begin
      we = 1'b1;
      wdata = color_q;
    end
  end

  assign in_i.ready = (state_q == SIdle) && !ovalid_q;
  assign out_o.valid = ovalid_q;
  assign out_o.color_index = idx_q;
  assign out_o.entry_count = ocount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      count_q  <= '0;
      ovalid_q <= 1'b0;
      color_q <= '0; ptr_q <= '0; pos_q <= '0; best_q <= '0; bestd_q <= '0;
      up_q <= 1'b0; first_q <= 1'b0; idx_q <= '0; ocount_q <= '0;
    end else begin
      if (ovalid_q && out_o.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (in_i.valid && in_i.ready) begin
            color_q <= in_i.color;
            idx_q   <= '0;
            unique case (action_e'(in_i.action))
              ActClear: begin
                count_q <= '0;
                state_q <= SOut;
              end
              ActLoad: begin
                ptr_q   <= count_q;
                state_q <= (count_q >= NW'(PaletteDepth)) ? SOut : SLdRd;
              end
              ActQuantize: begin
                if (count_q <= NW'(1)) state_q <= SOut;
                else begin
                  ptr_q   <= count_q - NW'(1);
                  state_q <= SMatRd;
                end
              end
              default: ;
            endcase
          end
        end
        // insertion: shift up while new word orders below ptr-1
        SLdRd: begin
          if (ptr_q == '0) begin
            count_q <= count_q + NW'(1);
            state_q <= SOut;
          end else state_q <= SLdWt;
        end
        SLdWt: state_q <= SLdCmp;
        SLdCmp: begin
          if (order_key(color_q) < order_key(rdata)) begin
            ptr_q   <= ptr_q - NW'(1);
            state_q <= SLdRd;
          end else begin
            count_q <= count_q + NW'(1);
            state_q <= SOut;
          end
        end
        // exact match scan, top down
        SMatRd: state_q <= SMatWt;
        SMatWt: state_q <= SMatCmp;
        SMatCmp: begin
          if (rdata == color_q) begin
            idx_q   <= 8'(ptr_q);
            state_q <= SOut;
          end else if (ptr_q == '0) begin
            state_q <= SPosRd;
          end else begin
            ptr_q   <= ptr_q - NW'(1);
            state_q <= SMatRd;
          end
        end
        // first entry not below color, or the last entry
        SPosRd: state_q <= SPosWt;
        SPosWt: state_q <= SPosCmp;
        SPosCmp: begin
          if (order_key(rdata) < order_key(color_q) && ptr_q != count_q - NW'(1)) begin
            ptr_q   <= ptr_q + NW'(1);
            state_q <= SPosRd;
          end else begin
            pos_q   <= ptr_q;
            best_q  <= ptr_q;
            first_q <= 1'b1;
            up_q    <= 1'b0;
            state_q <= SWalkRd;
          end
        end
        SWalkRd: state_q <= SWalkWt;
        SWalkWt: state_q <= SWalkD;
        SWalkD: state_q <= SWalkCmp;
        SWalkCmp: begin
          logic stop;
          stop = 1'b0;
          if (first_q) begin
            bestd_q <= dist_sq;
            first_q <= 1'b0;
          end else if (22'(bestd_q) < sq) begin
            stop = 1'b1;
          end else if (dist_sq < bestd_q) begin
            bestd_q <= dist_sq;
            best_q  <= ptr_q;
          end
          if (!up_q && !stop && ptr_q != '0) begin
            ptr_q   <= ptr_q - NW'(1);
            state_q <= SWalkRd;
          end else if (!up_q) begin
            up_q <= 1'b1;
            if (pos_q + NW'(1) < count_q) begin
              ptr_q   <= pos_q + NW'(1);
              state_q <= SWalkRd;
            end else state_q <= SOut;
          end else if (!stop && ptr_q + NW'(1) < count_q) begin
            ptr_q   <= ptr_q + NW'(1);
            state_q <= SWalkRd;
          end else state_q <= SOut;
        end
        SOut: begin
          if (up_q) idx_q <= 8'(best_q);
          up_q     <= 1'b0;
          ovalid_q <= 1'b1;
          ocount_q <= 9'(count_q);
          state_q  <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/pnc_ram.sv @@
`default_nettype none
module pnc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ design/pnc_dist.sv @@
`default_nettype none
// Squared RGBA distance and signed difference sum; registered result.
module pnc_dist (
  input  wire logic        clk_i,
  input  wire logic [31:0] entry_i,
  input  wire logic [31:0] color_i,
  output logic      [17:0] dist_o,
  output logic      [10:0] sum_o
);
  logic signed [8:0] d [4];
  logic signed [17:0] dw;
  logic [17:0] dd;
  logic signed [10:0] ss;
  always_comb begin
    dd = '0;
    ss = '0;
    dw = '0;
    for (int k = 0; k < 4; k++) begin
      d[k] = $signed({1'b0, entry_i[8*k +: 8]}) - $signed({1'b0, color_i[8*k +: 8]});
      dw = 18'(d[k]);
      dd = dd + unsigned'(dw * dw);
      ss = ss + 11'(d[k]);
    end
  end
  always_ff @(posedge clk_i) begin
    dist_o <= dd;
    sum_o  <= ss;
  end
endmodule
`default_nettype wire

@@ design/pnc_checker.sv @@
`default_nettype none
module pnc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] color_index_i,
  input wire logic [8:0] entry_count_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(color_index_i) &&
      $stable(entry_count_i)) else $error("out hold");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("ready with pending word");
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i) else $error("result right after accept");
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i) else $error("result repeated");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown({color_index_i, entry_count_i})) else $error("unknown result");
endmodule

bind palette_nearest_color_core pnc_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(in_i.valid), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .color_index_i(out_o.color_index), .entry_count_i(out_o.entry_count)
);
`default_nettype wire

@@ tb/palette_nearest_color_core_test.sv @@
module palette_nearest_color_core_test
  import pnc_pkg::*;
();
  localparam int unsigned Depth = 256;
  localparam int unsigned CycleLimit = 20000000;

  typedef struct packed {
    logic [7:0] color_index;
    logic [8:0] entry_count;
  } lookup_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pnc_in_if  word_in ();
  pnc_out_if word_out ();

  palette_nearest_color_core #(.PaletteDepth(Depth)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (word_in.sink),
    .out_o (word_out.source)
  );

  // 4-unit period: high 2, low 2.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow palette kept in sorted order, mirrors what the block holds.
  logic [31:0] shadow_pal [Depth];
  int unsigned shadow_count;
  lookup_result_t pending_q[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit idle_enable;

  function automatic int chan(input logic [31:0] c, input int sh);
    return int'((c >> sh) & 32'hFF);
  endfunction

  // Strict order: channel sum, then a, r, g, b.
  function automatic bit sorts_below(input logic [31:0] x, input logic [31:0] y);
    int sx, sy;
    sx = chan(x, 0) + chan(x, 8) + chan(x, 16) + chan(x, 24);
    sy = chan(y, 0) + chan(y, 8) + chan(y, 16) + chan(y, 24);
    if (sx != sy) return sx < sy;
    if (chan(x, 24) != chan(y, 24)) return chan(x, 24) < chan(y, 24);
    if (chan(x, 0) != chan(y, 0)) return chan(x, 0) < chan(y, 0);
    if (chan(x, 8) != chan(y, 8)) return chan(x, 8) < chan(y, 8);
    return chan(x, 16) < chan(y, 16);
  endfunction

  function automatic int sq_dist(input logic [31:0] e, input logic [31:0] c,
                                 output int diff_sum);
    int dr, dg, db, da;
    dr = chan(e, 0) - chan(c, 0);
    dg = chan(e, 8) - chan(c, 8);
    db = chan(e, 16) - chan(c, 16);
    da = chan(e, 24) - chan(c, 24);
    diff_sum = dr + dg + db + da;
    return dr * dr + dg * dg + db * db + da * da;
  endfunction

  function automatic int unsigned nearest_index(input logic [31:0] c);
    int unsigned pos, best;
    int bestd, s, d;
    if (shadow_count <= 1) return 0;
    // Exact match wins, highest copy first.
    for (int i = int'(shadow_count) - 1; i >= 0; i--)
      if (shadow_pal[i] == c) return i;
    pos = 0;
    while (pos < shadow_count && sorts_below(shadow_pal[pos], c)) pos++;
    if (pos == shadow_count) pos = shadow_count - 1;
    best = pos;
    bestd = sq_dist(shadow_pal[pos], c, s);
    // Walk down, then up; stop a side once the sum bound passes the best.
    for (int k = int'(pos) - 1; k >= 0; k--) begin
      d = sq_dist(shadow_pal[k], c, s);
      if (s * s / 4 > bestd) break;
      if (d < bestd) begin
        best = k;
        bestd = d;
      end
    end
    for (int unsigned i = pos + 1; i < shadow_count; i++) begin
      d = sq_dist(shadow_pal[i], c, s);
      if (s * s / 4 > bestd) break;
      if (d < bestd) begin
        best = i;
        bestd = d;
      end
    end
    return best;
  endfunction

  // Update the shadow palette and queue the word the block must return.
  task automatic predict_word(input action_e act, input logic [31:0] c);
    lookup_result_t r;
    int unsigned pos;
    r.color_index = '0;
    case (act)
      ActClear: begin
        shadow_count = 0;
      end
      ActLoad: begin
        if (shadow_count < Depth) begin
          pos = shadow_count;
          while (pos > 0 && sorts_below(c, shadow_pal[pos - 1])) begin
            shadow_pal[pos] = shadow_pal[pos - 1];
            pos--;
          end
          shadow_pal[pos] = c;
          shadow_count++;
        end
      end
      ActQuantize: begin
        r.color_index = 8'(nearest_index(c));
      end
      default: return;  // no result for the spare action
    endcase
    r.entry_count = 9'(shadow_count);
    pending_q = {pending_q, r};
  endtask

  // Drive one word, hold it until accepted; optional idle burst first.
  task automatic send_word(input action_e act, input logic [31:0] c);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      word_in.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    word_in.valid <= 1'b1;
    word_in.action <= act;
    word_in.color <= c;
    do @(posedge clk_i); while (!word_in.ready);
    predict_word(act, c);
    @(negedge clk_i);
  endtask

  // Sink side: random stall bursts on ready.
  initial begin
    int unsigned stall;
    word_out.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        stall--;
        word_out.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 5) - 1;
        word_out.ready <= 1'b0;
      end else begin
        word_out.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    lookup_result_t exp_r;
    if (rst_ni && word_out.valid && word_out.ready) begin
      if (pending_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: index %0d count %0d",
                   word_out.color_index, word_out.entry_count);
      end else begin
        exp_r = pending_q.pop_front();
        if (word_out.color_index !== exp_r.color_index ||
            word_out.entry_count !== exp_r.entry_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: index exp %0d got %0d, count exp %0d got %0d",
                     exp_r.color_index, word_out.color_index,
                     exp_r.entry_count, word_out.entry_count);
        end
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] rand_color();
    return $urandom();
  endfunction

  // Color near an existing palette entry, to exercise the neighbor walk.
  function automatic logic [31:0] near_color();
    logic [31:0] c;
    if (shadow_count == 0) return $urandom();
    c = shadow_pal[$urandom_range(0, shadow_count - 1)];
    for (int sh = 0; sh < 32; sh += 8)
      c[sh +: 8] = 8'(int'(c[sh +: 8]) + $urandom_range(0, 15) - 8);
    return c;
  endfunction

  task automatic test_corners();
    send_word(ActQuantize, 32'h0);          // empty palette
    send_word(ActLoad, 32'hFFFF_FFFF);
    send_word(ActQuantize, 32'h1234_5678);  // single entry
    send_word(ActLoad, 32'h0000_0000);
    send_word(ActLoad, 32'h8000_0000);
    send_word(ActLoad, 32'h0000_0080);
    send_word(ActLoad, 32'h0080_0000);
    send_word(ActLoad, 32'h0000_8000);
    send_word(ActLoad, 32'h0000_8000);      // duplicate kept
    send_word(ActQuantize, 32'h0000_8000);  // exact match, last copy
    send_word(ActQuantize, 32'hFFFF_FFFF);
    send_word(ActQuantize, 32'hFFFF_FFFE);
    send_word(ActQuantize, 32'h0000_0001);
    send_word(ActQuantize, 32'h4040_4040);
    send_word(ActNone, 32'hFFFF_FFFF);      // spare action, no result
    send_word(ActQuantize, 32'h7F7F_7F7F);
    send_word(ActClear, 32'h0);
    send_word(ActQuantize, 32'hAAAA_5555);
  endtask

  task automatic test_full_palette();
    send_word(ActClear, 32'hFFFF_FFFF);
    repeat (Depth) send_word(ActLoad, rand_color());
    send_word(ActLoad, 32'h0102_0304);      // ignored when full
    repeat (40) send_word(ActQuantize, ($urandom_range(0, 1) ? near_color() : rand_color()));
    send_word(ActQuantize, shadow_pal[Depth - 1]);
  endtask

  // Sessions: clear, load a modest palette, quantize mostly near colors.
  task automatic test_random_sessions(input int unsigned n_words);
    int unsigned sent;
    int unsigned r;
    sent = 0;
    while (sent < n_words) begin
      send_word(ActClear, rand_color());
      sent++;
      repeat ($urandom_range(0, 24)) begin
        send_word(ActLoad, ($urandom_range(0, 2) == 0) ? near_color() : rand_color());
        sent++;
      end
      repeat ($urandom_range(5, 30)) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_word(ActNone, rand_color());
        else if (r == 1) begin
          send_word(ActLoad, rand_color());
          sent++;
        end else begin
          send_word(ActQuantize, (r < 12) ? near_color() : rand_color());
          sent++;
        end
      end
    end
  endtask

  initial begin
    word_in.valid = 1'b0;
    word_in.action = ActClear;
    word_in.color = '0;
    shadow_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    idle_enable = 1'b1;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corners();
    test_full_palette();
    test_random_sessions(800);
    // Last stretch at full rate on both sides.
    idle_enable = 1'b0;
    test_random_sessions(250);
    word_in.valid <= 1'b0;

    // Drain, then let any trailing work settle.
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 20) @(posedge clk_i);

    if (mismatch_count == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
